// ----- design/jebs_pkg.sv -----
// Package for the JSON entry boundary scanner: scan phases, result kinds,
// character codes and the result record shared by the scanner logic.
// No dependencies.
`timescale 1ns / 1ps

package jebs_pkg;

    // Default sizing
    localparam int MAX_DEPTH_DEF     = 15;
    localparam int POSITION_BITS_DEF = 16;

    // Output field widths
    localparam int KIND_BITS   = 2;
    localparam int OFFSET_BITS = 16;
    localparam int NUMBER_BITS = 16;

    // Result queue sizing
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    // Character codes
    localparam logic [7:0] CH_LBRACE  = 8'h7B;
    localparam logic [7:0] CH_LBRACK  = 8'h5B;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_RBRACE  = 8'h7D;
    localparam logic [7:0] CH_RBRACK  = 8'h5D;
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_BSLASH  = 8'h5C;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_NUL     = 8'h00;

    typedef enum logic [2:0] {
        PH_OPEN        = 3'd0,
        PH_LEAD        = 3'd1,
        PH_SCAN        = 3'd2,
        PH_AWAIT_COMMA = 3'd3,
        PH_AFTER_COMMA = 3'd4,
        PH_DONE        = 3'd5
    } t_phase;

    typedef enum logic [1:0] {
        EV_NONE     = 2'd0,
        EV_FINISH   = 2'd1,
        EV_OVERFLOW = 2'd2
    } t_event;

    typedef enum logic [KIND_BITS-1:0] {
        KIND_ENTRY    = 2'd0,
        KIND_FINISH   = 2'd1,
        KIND_OVERFLOW = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind                  kind;
        logic [OFFSET_BITS-1:0] offset;
        logic [NUMBER_BITS-1:0] number;
        logic                   last;
    } t_result;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

endpackage

// ----- design/json_entry_boundary_scanner.sv -----
// Top level of the JSON entry boundary scanner: per-byte scan state, result
// builder and a four-entry result queue toward the output stream.
// Depends on jebs_pkg.
`timescale 1ns / 1ps

// Channel     Dir  Beat contents (low bit first)
// s_axis      in   tdata[7:0] text_byte, tlast end_of_text
// m_axis      out  tdata[15:0] entry_offset, tdata[31:16] entry_number,
//                  tuser[1:0] result_kind, tlast last_of_run
//
// One input byte is taken per cycle while s_axis tready is high. A byte yields
// zero, one or two results; the output side drains one per cycle while m_axis
// tready is high, from a four-entry queue, so bytes with two results are paced
// by the output port. s_axis tready is low while fewer than two queue slots are
// free. i_rst_n is synchronous, active low; it empties the queue and returns
// the scan to the state that expects the opening bracket at offset zero.
module json_entry_boundary_scanner
    import jebs_pkg::*;
#(
    parameter int MAX_DEPTH     = MAX_DEPTH_DEF,
    parameter int POSITION_BITS = POSITION_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // s_axis: tdata = text_byte[7:0]
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    input  logic [7:0]                         i_s_axis_tdata,
    input  logic                               i_s_axis_tlast,
    // m_axis: tdata = entry_offset[15:0], entry_number[31:16]
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    output logic [OFFSET_BITS+NUMBER_BITS-1:0] o_m_axis_tdata,
    // m_axis: tuser = result_kind[1:0]
    output logic [KIND_BITS-1:0]               o_m_axis_tuser,
    output logic                               o_m_axis_tlast
);

    localparam int DEPTH_BITS = $clog2(MAX_DEPTH + 1);
    localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = DEPTH_BITS'(MAX_DEPTH);
    localparam logic [DEPTH_BITS-1:0] DEPTH_ONE = DEPTH_BITS'(1);
    localparam logic [NUMBER_BITS-1:0] COUNT_SAT = '1;

    // Scan state
    t_phase                   r_phase,   n_phase;
    logic                     r_in_str,  n_in_str;
    logic                     r_esc,     n_esc;
    logic [DEPTH_BITS-1:0]    r_brace,   n_brace;
    logic [DEPTH_BITS-1:0]    r_bracket, n_bracket;
    logic [NUMBER_BITS-1:0]   r_entries, n_entries;
    logic [POSITION_BITS-1:0] r_pos;

    // Result queue
    t_result                  r_fifo [FIFO_DEPTH];
    logic [FIFO_AW-1:0]       r_head;
    logic [FIFO_AW-1:0]       r_tail;
    logic [FIFO_AW:0]         r_count;

    logic                     w_in_acc;
    logic                     w_out_acc;
    logic [7:0]               w_c;
    logic                     w_start;
    t_event                   w_event;
    logic                     w_do_scan;
    logic [31:0]              w_pos_ext;
    logic [1:0]               w_nres;
    t_result                  w_res0;
    t_result                  w_res1;
    t_result                  w_ev_res;
    t_result                  w_tail_res;
    logic                     w_tail_fin;
    logic [FIFO_AW-1:0]       w_tail1;

    assign w_in_acc  = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_acc = o_m_axis_tvalid && i_m_axis_tready;
    assign w_c       = i_s_axis_tdata;
    assign w_pos_ext = 32'(r_pos);
    assign w_tail1   = r_tail + FIFO_AW'(1);

    // Next scan state for the byte on the input
    always_comb begin
        n_phase   = r_phase;
        n_in_str  = r_in_str;
        n_esc     = r_esc;
        n_brace   = r_brace;
        n_bracket = r_bracket;
        n_entries = r_entries;
        w_start   = 1'b0;
        w_event   = EV_NONE;
        w_do_scan = 1'b0;

        if (r_phase != PH_DONE) begin
            if (w_c == CH_NUL) begin
                w_event = EV_FINISH;
            end else begin
                unique case (r_phase)
                    PH_OPEN: begin
                        if ((w_c == CH_LBRACE) || (w_c == CH_LBRACK)) begin
                            n_phase = PH_LEAD;
                        end else begin
                            w_event = EV_FINISH;
                        end
                    end
                    PH_LEAD, PH_AFTER_COMMA: begin
                        if (!is_ws(w_c)) begin
                            if ((w_c == CH_RBRACE) || (w_c == CH_RBRACK) ||
                                ((r_phase == PH_LEAD) && (w_c == CH_COMMA))) begin
                                w_event = EV_FINISH;
                            end else begin
                                w_start   = 1'b1;
                                n_entries = (r_entries != COUNT_SAT) ?
                                            r_entries + NUMBER_BITS'(1) : r_entries;
                                n_phase   = PH_SCAN;
                                w_do_scan = 1'b1;
                            end
                        end
                    end
                    PH_SCAN: begin
                        w_do_scan = 1'b1;
                    end
                    PH_AWAIT_COMMA: begin
                        if (!is_ws(w_c)) begin
                            if (w_c == CH_COMMA) begin
                                n_phase = PH_AFTER_COMMA;
                            end else begin
                                w_event = EV_FINISH;
                            end
                        end
                    end
                    default: begin
                        w_event = EV_FINISH;
                    end
                endcase

                // Track strings, escapes and nesting inside an entry
                if (w_do_scan) begin
                    if (r_in_str) begin
                        if (r_esc) begin
                            n_esc = 1'b0;
                        end else if (w_c == CH_BSLASH) begin
                            n_esc = 1'b1;
                        end else if (w_c == CH_QUOTE) begin
                            n_in_str = 1'b0;
                        end
                    end else begin
                        unique case (w_c)
                            CH_QUOTE:  n_in_str = 1'b1;
                            CH_BSLASH: w_event  = EV_FINISH;
                            CH_LBRACE: begin
                                if (r_brace >= DEPTH_MAX) begin
                                    w_event = EV_OVERFLOW;
                                end else begin
                                    n_brace = r_brace + DEPTH_ONE;
                                end
                            end
                            CH_LBRACK: begin
                                if (r_bracket >= DEPTH_MAX) begin
                                    w_event = EV_OVERFLOW;
                                end else begin
                                    n_bracket = r_bracket + DEPTH_ONE;
                                end
                            end
                            CH_COMMA: begin
                                if ((r_brace == '0) && (r_bracket == '0)) begin
                                    n_phase = PH_AFTER_COMMA;
                                end
                            end
                            CH_RBRACE: begin
                                if (r_brace == '0) begin
                                    w_event = EV_FINISH;
                                end else begin
                                    n_brace = r_brace - DEPTH_ONE;
                                    if ((r_brace == DEPTH_ONE) && (r_bracket == '0)) begin
                                        n_phase = PH_AWAIT_COMMA;
                                    end
                                end
                            end
                            CH_RBRACK: begin
                                if (r_bracket == '0) begin
                                    w_event = EV_FINISH;
                                end else begin
                                    n_bracket = r_bracket - DEPTH_ONE;
                                    if ((r_bracket == DEPTH_ONE) && (r_brace == '0)) begin
                                        n_phase = PH_AWAIT_COMMA;
                                    end
                                end
                            end
                            default: ;
                        endcase
                    end
                end
            end

            if (w_event != EV_NONE) begin
                n_phase = PH_DONE;
            end
        end
    end

    // Build the results caused by this byte
    always_comb begin
        w_tail_fin = i_s_axis_tlast && (n_phase != PH_DONE);

        w_ev_res.kind   = (w_event == EV_OVERFLOW) ? KIND_OVERFLOW : KIND_FINISH;
        w_ev_res.offset = '0;
        w_ev_res.number = n_entries;
        w_ev_res.last   = 1'b1;

        w_tail_res.kind   = KIND_FINISH;
        w_tail_res.offset = '0;
        w_tail_res.number = n_entries;
        w_tail_res.last   = 1'b1;

        w_res0.kind   = KIND_ENTRY;
        w_res0.offset = w_pos_ext[OFFSET_BITS-1:0];
        w_res0.number = r_entries;
        w_res0.last   = 1'b1;
        w_res1        = w_tail_res;
        w_nres        = 2'd0;

        if (w_start) begin
            if (w_event != EV_NONE) begin
                w_res0.last = 1'b0;
                w_res1      = w_ev_res;
                w_nres      = 2'd2;
            end else if (w_tail_fin) begin
                w_res0.last = 1'b0;
                w_nres      = 2'd2;
            end else begin
                w_nres = 2'd1;
            end
        end else if (w_event != EV_NONE) begin
            w_res0 = w_ev_res;
            w_nres = 2'd1;
        end else if (w_tail_fin) begin
            w_res0 = w_tail_res;
            w_nres = 2'd1;
        end
    end

    // Advance scan state on each accepted beat; end of text restarts the scan
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_OPEN;
            r_in_str  <= 1'b0;
            r_esc     <= 1'b0;
            r_brace   <= '0;
            r_bracket <= '0;
            r_entries <= '0;
            r_pos     <= '0;
        end else if (w_in_acc) begin
            if (i_s_axis_tlast) begin
                r_phase   <= PH_OPEN;
                r_in_str  <= 1'b0;
                r_esc     <= 1'b0;
                r_brace   <= '0;
                r_bracket <= '0;
                r_entries <= '0;
                r_pos     <= '0;
            end else begin
                r_phase   <= n_phase;
                r_in_str  <= n_in_str;
                r_esc     <= n_esc;
                r_brace   <= n_brace;
                r_bracket <= n_bracket;
                r_entries <= n_entries;
                r_pos     <= r_pos + POSITION_BITS'(1);
            end
        end
    end

    // Queue pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            if (w_out_acc) begin
                r_head <= r_head + FIFO_AW'(1);
            end
            if (w_in_acc) begin
                r_tail <= r_tail + FIFO_AW'(w_nres);
            end
            r_count <= r_count
                     + ((w_in_acc) ? (FIFO_AW + 1)'(w_nres) : '0)
                     - ((w_out_acc) ? (FIFO_AW + 1)'(1) : '0);
        end
    end

    // Hold results in the queue slots
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < FIFO_DEPTH; i++) begin
            if (w_in_acc && (w_nres != 2'd0) && (r_tail == FIFO_AW'(i))) begin
                r_fifo[i] <= w_res0;
            end else if (w_in_acc && (w_nres == 2'd2) && (w_tail1 == FIFO_AW'(i))) begin
                r_fifo[i] <= w_res1;
            end
        end
    end

    // Drive the ports
    assign o_s_axis_tready = (r_count <= (FIFO_AW + 1)'(FIFO_DEPTH - 2));
    assign o_m_axis_tvalid = (r_count != '0);
    assign o_m_axis_tdata  = {r_fifo[r_head].number, r_fifo[r_head].offset};
    assign o_m_axis_tuser  = r_fifo[r_head].kind;
    assign o_m_axis_tlast  = r_fifo[r_head].last;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (FIFO_AW + 1)'(FIFO_DEPTH))
        else $error("result queue overfilled");

    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_brace <= DEPTH_MAX) && (r_bracket <= DEPTH_MAX))
        else $error("nesting depth beyond bound");

    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_s_axis_tlast) |=> (r_phase == PH_OPEN) && (r_pos == '0))
        else $error("scan did not restart after end of text");

    a_done_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && (r_phase == PH_DONE) && !i_s_axis_tlast) |=>
            (r_count <= $past(r_count)))
        else $error("finished scan produced a result");

    a_overflow_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (o_m_axis_tuser == KIND_OVERFLOW)) |-> o_m_axis_tlast)
        else $error("overflow result not final for its byte");
`endif

endmodule

// ----- bench/jebs_scan_checker.sv -----
// Checker for the JSON entry boundary scanner: watches both stream channels,
// predicts the result beats of every accepted text byte and compares them.
// Depends on jebs_pkg.
`timescale 1ns / 1ps

module jebs_scan_checker
    import jebs_pkg::*;
(
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_tvalid,
    input  logic                               i_s_tready,
    input  logic [7:0]                         i_s_tdata,
    input  logic                               i_s_tlast,
    input  logic                               i_m_tvalid,
    input  logic                               i_m_tready,
    input  logic [OFFSET_BITS+NUMBER_BITS-1:0] i_m_tdata,
    input  logic [KIND_BITS-1:0]               i_m_tuser,
    input  logic                               i_m_tlast,
    output int                                 o_fail_count,
    output int                                 o_pending
);

    // Scan state mirrored from the byte stream
    t_phase      phase;
    logic        in_quotes;
    logic        skip_next;
    int          curly_level;
    int          bracket_nest;
    logic [15:0] entry_count;
    logic [15:0] text_offset;

    t_result byte_results[$];
    t_result expected_boundaries[$];
    int      mismatches = 0;

    function automatic bit is_blank(input logic [7:0] ch);
        return ch == CH_SPACE || (ch >= CH_TAB && ch <= CH_CR);
    endfunction

    task automatic clear_scan();
        phase        = PH_OPEN;
        in_quotes    = 1'b0;
        skip_next    = 1'b0;
        curly_level  = 0;
        bracket_nest = 0;
        entry_count  = '0;
        text_offset  = '0;
    endtask

    task automatic add_result(input t_kind k, input logic [15:0] off, input logic [15:0] num);
        t_result r;
        r.kind   = k;
        r.offset = off;
        r.number = num;
        r.last   = 1'b0;
        byte_results.push_back(r);
    endtask

    // Track strings, escapes and nesting for one byte inside an entry
    function automatic t_event track_entry_byte(input logic [7:0] ch);
        if (in_quotes) begin
            if (skip_next)
                skip_next = 1'b0;
            else if (ch == CH_BSLASH)
                skip_next = 1'b1;
            else if (ch == CH_QUOTE)
                in_quotes = 1'b0;
            return EV_NONE;
        end
        case (ch)
            CH_QUOTE: in_quotes = 1'b1;
            CH_BSLASH: return EV_FINISH;
            CH_LBRACE: begin
                if (curly_level >= MAX_DEPTH_DEF) return EV_OVERFLOW;
                curly_level++;
            end
            CH_LBRACK: begin
                if (bracket_nest >= MAX_DEPTH_DEF) return EV_OVERFLOW;
                bracket_nest++;
            end
            CH_COMMA: begin
                if (curly_level == 0 && bracket_nest == 0) phase = PH_AFTER_COMMA;
            end
            CH_RBRACE: begin
                if (curly_level == 0) return EV_FINISH;
                curly_level--;
                if (curly_level == 0 && bracket_nest == 0) phase = PH_AWAIT_COMMA;
            end
            CH_RBRACK: begin
                if (bracket_nest == 0) return EV_FINISH;
                bracket_nest--;
                if (curly_level == 0 && bracket_nest == 0) phase = PH_AWAIT_COMMA;
            end
            default: ;
        endcase
        return EV_NONE;
    endfunction

    // Work out the result beats that one text byte causes
    task automatic scan_text_byte(input logic [7:0] ch, input logic eot);
        t_event      ev;
        logic [15:0] at;
        at = text_offset;
        text_offset = text_offset + 16'd1;
        ev = EV_NONE;
        byte_results.delete();
        if (phase != PH_DONE) begin
            if (ch == CH_NUL) begin
                ev = EV_FINISH;
            end else begin
                case (phase)
                    PH_OPEN: begin
                        if (ch == CH_LBRACE || ch == CH_LBRACK) phase = PH_LEAD;
                        else ev = EV_FINISH;
                    end
                    PH_LEAD, PH_AFTER_COMMA: begin
                        if (!is_blank(ch)) begin
                            if (ch == CH_RBRACE || ch == CH_RBRACK ||
                                (phase == PH_LEAD && ch == CH_COMMA)) begin
                                ev = EV_FINISH;
                            end else begin
                                add_result(KIND_ENTRY, at, entry_count);
                                if (entry_count != 16'hFFFF) entry_count++;
                                phase = PH_SCAN;
                                ev = track_entry_byte(ch);
                            end
                        end
                    end
                    PH_SCAN: ev = track_entry_byte(ch);
                    PH_AWAIT_COMMA: begin
                        if (!is_blank(ch)) begin
                            if (ch == CH_COMMA) phase = PH_AFTER_COMMA;
                            else ev = EV_FINISH;
                        end
                    end
                    default: ev = EV_FINISH;
                endcase
            end
            if (ev == EV_FINISH) begin
                add_result(KIND_FINISH, '0, entry_count);
                phase = PH_DONE;
            end else if (ev == EV_OVERFLOW) begin
                add_result(KIND_OVERFLOW, '0, entry_count);
                phase = PH_DONE;
            end
        end
        // Close the text: report the count if still scanning, then start over
        if (eot) begin
            if (phase != PH_DONE) add_result(KIND_FINISH, '0, entry_count);
            clear_scan();
        end
        if (byte_results.size() > 0) byte_results[byte_results.size()-1].last = 1'b1;
        foreach (byte_results[i]) expected_boundaries.push_back(byte_results[i]);
    endtask

    task automatic note_mismatch(input string what, input t_result want, input t_result got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t ns: %s: expected kind=%0d offset=%0d number=%0d last=%0d,",
                     $time, what, want.kind, want.offset, want.number, want.last,
                     " got kind=%0d offset=%0d number=%0d last=%0d",
                     got.kind, got.offset, got.number, got.last);
    endtask

    // Compare output beats first, then predict from the input beat
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            clear_scan();
            expected_boundaries.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                got.kind   = t_kind'(i_m_tuser);
                got.offset = i_m_tdata[OFFSET_BITS-1:0];
                got.number = i_m_tdata[OFFSET_BITS+NUMBER_BITS-1:OFFSET_BITS];
                got.last   = i_m_tlast;
                if (expected_boundaries.size() == 0) begin
                    want = '0;
                    note_mismatch("unexpected beat", want, got);
                end else begin
                    want = expected_boundaries.pop_front();
                    if (got.kind !== want.kind || got.offset !== want.offset ||
                        got.number !== want.number || got.last !== want.last)
                        note_mismatch("wrong beat", want, got);
                end
            end
            if (i_s_tvalid && i_s_tready) scan_text_byte(i_s_tdata, i_s_tlast);
        end
        o_fail_count <= mismatches;
        o_pending    <= expected_boundaries.size();
    end

endmodule

// ----- bench/tb_top.sv -----
// Top of the scanner testbench: clock, reset, JSON text stimulus with random
// gaps and output stalls, watchdog and verdict.
// Depends on jebs_pkg, json_entry_boundary_scanner and jebs_scan_checker.
`timescale 1ns / 1ps

module tb_top
    import jebs_pkg::*;
();

    localparam int WATCHDOG_LIMIT   = 2000;
    localparam int RANDOM_BYTES     = 930;
    localparam logic [7:0] CH_ZERO  = "0";
    localparam logic [7:0] CH_COLON = ":";
    localparam logic [7:0] CH_MINUS = "-";
    localparam logic [7:0] CH_A     = "a";
    localparam logic [7:0] CH_Z     = "z";

    logic                               i_clk    = 1'b0;
    logic                               i_rst_n  = 1'b0;
    logic                               s_tvalid = 1'b0;
    logic                               s_tready;
    logic [7:0]                         s_tdata  = '0;
    logic                               s_tlast  = 1'b0;
    logic                               m_tvalid;
    logic                               m_tready = 1'b0;
    logic [OFFSET_BITS+NUMBER_BITS-1:0] m_tdata;
    logic [KIND_BITS-1:0]               m_tuser;
    logic                               m_tlast;

    int         fail_count;
    int         pending;
    logic [7:0] text_q[$];
    bit         src_calm   = 1'b0;
    bit         sink_calm  = 1'b0;
    int         sink_stall = 0;
    int         sink_beats = 0;
    int         idle_cycles = 0;
    int         random_sent = 0;

    always #2 i_clk = ~i_clk;

    json_entry_boundary_scanner DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tlast  (s_tlast),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .o_m_axis_tlast  (m_tlast)
    );

    jebs_scan_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tlast    (s_tlast),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .i_m_tlast    (m_tlast),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Stall the result stream at random after each beat, with calm stretches
    always @(posedge i_clk) begin
        if (m_tready && m_tvalid) begin
            sink_beats++;
            if (sink_beats % 100 == 0) sink_calm = ($urandom_range(0, 3) == 0);
            sink_stall = sink_calm ? 0 : $urandom_range(0, 5);
        end else if (sink_stall > 0) begin
            sink_stall--;
        end
        m_tready <= (sink_stall == 0);
    end

    // Abort when no beat moves on either side for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic eot);
        int gap;
        gap = src_calm ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= eot;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
    endtask

    // Send the staged text, marking its final byte as end of text
    task automatic send_text();
        int i;
        for (i = 0; i < text_q.size(); i++) send_byte(text_q[i], i == text_q.size() - 1);
    endtask

    task automatic load_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++) text_q.push_back(s[i]);
    endtask

    task automatic add_blanks();
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 2))
                text_q.push_back($urandom_range(0, 5) == 0 ? CH_SPACE :
                                 CH_TAB + 8'($urandom_range(0, 4)));
    endtask

    task automatic add_number();
        if ($urandom_range(0, 3) == 0) text_q.push_back(CH_MINUS);
        repeat ($urandom_range(1, 3)) text_q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
    endtask

    // Quoted string with random content; quotes and backslashes are escaped
    task automatic add_string();
        logic [7:0] ch;
        text_q.push_back(CH_QUOTE);
        repeat ($urandom_range(0, 4)) begin
            ch = 8'($urandom_range(1, 255));
            if ($urandom_range(0, 2) == 0) ch = 8'($urandom_range(CH_A, CH_Z));
            if (ch == CH_QUOTE || ch == CH_BSLASH || $urandom_range(0, 7) == 0)
                text_q.push_back(CH_BSLASH);
            text_q.push_back(ch);
        end
        text_q.push_back(CH_QUOTE);
    endtask

    task automatic add_value(input int lvl);
        int pick;
        int cnt;
        int k;
        pick = (lvl >= 3) ? $urandom_range(0, 4) : $urandom_range(0, 8);
        add_blanks();
        case (pick)
            0, 1: add_number();
            2, 3: add_string();
            4: load_text($urandom_range(0, 1) ? "true" : "null");
            5, 6: begin
                text_q.push_back(CH_LBRACK);
                cnt = $urandom_range(0, 3);
                for (k = 0; k < cnt; k++) begin
                    if (k > 0) text_q.push_back(CH_COMMA);
                    add_value(lvl + 1);
                end
                add_blanks();
                text_q.push_back(CH_RBRACK);
            end
            default: begin
                text_q.push_back(CH_LBRACE);
                cnt = $urandom_range(0, 3);
                for (k = 0; k < cnt; k++) begin
                    if (k > 0) text_q.push_back(CH_COMMA);
                    add_blanks();
                    add_string();
                    text_q.push_back(CH_COLON);
                    add_value(lvl + 1);
                end
                add_blanks();
                text_q.push_back(CH_RBRACE);
            end
        endcase
        add_blanks();
    endtask

    // Mostly well-formed containers, some broken, some noise or deep nesting
    task automatic build_random_text();
        int         style;
        int         cnt;
        int         k;
        bit         as_object;
        logic [7:0] opener;
        text_q.delete();
        style = $urandom_range(0, 19);
        if (style == 0) begin
            repeat ($urandom_range(1, 6)) text_q.push_back(8'($urandom_range(0, 255)));
        end else if (style == 1) begin
            text_q.push_back($urandom_range(0, 1) ? CH_LBRACK : CH_LBRACE);
            opener = $urandom_range(0, 1) ? CH_LBRACE : CH_LBRACK;
            repeat ($urandom_range(14, 17)) text_q.push_back(opener);
            text_q.push_back(CH_ZERO);
        end else begin
            as_object = $urandom_range(0, 1);
            text_q.push_back(as_object ? CH_LBRACE : CH_LBRACK);
            cnt = $urandom_range(0, 5);
            for (k = 0; k < cnt; k++) begin
                if (k > 0) text_q.push_back(CH_COMMA);
                if (as_object) begin
                    add_blanks();
                    add_string();
                    text_q.push_back(CH_COLON);
                end
                add_value(1);
            end
            add_blanks();
            text_q.push_back(as_object ? CH_RBRACE : CH_RBRACK);
            if ($urandom_range(0, 3) == 0) add_blanks();
            // Break a few texts: overwrite one byte or cut the text short
            if (style <= 5) begin
                k = $urandom_range(0, text_q.size() - 1);
                if ($urandom_range(0, 1) == 0)
                    text_q[k] = 8'($urandom_range(0, 255));
                else
                    while (text_q.size() > k + 1) void'(text_q.pop_back());
            end
        end
    endtask

    task automatic directed_text(input string s);
        text_q.delete();
        load_text(s);
        src_calm = ($urandom_range(0, 2) == 0);
        send_text();
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: bad opener, empty containers, escapes, closes, early ends
        directed_text("x");
        directed_text("{ }");
        directed_text("[ ,1]");
        directed_text("[1,\"a\\\"b\",{\"k\":[2]} ]");
        directed_text("[\\1]");
        directed_text("[1, ]");
        directed_text("[[1] x]");
        directed_text("[1]zz");
        directed_text("{\"a\":1");
        directed_text("[1,");
        // Zero byte ends the scan; the rest of the text is ignored
        text_q.delete();
        load_text("[1");
        text_q.push_back(CH_NUL);
        load_text("2]");
        send_text();
        // High bytes inside a string
        text_q.delete();
        load_text("[\"");
        text_q.push_back(8'hFF);
        text_q.push_back(8'h80);
        load_text("\"]");
        send_text();
        // Nesting right at the bound, then one past it for each kind
        text_q.delete();
        text_q.push_back(CH_LBRACK);
        repeat (MAX_DEPTH_DEF) text_q.push_back(CH_LBRACK);
        send_text();
        text_q.delete();
        text_q.push_back(CH_LBRACK);
        repeat (MAX_DEPTH_DEF + 1) text_q.push_back(CH_LBRACK);
        send_text();
        text_q.delete();
        text_q.push_back(CH_LBRACE);
        repeat (MAX_DEPTH_DEF + 1) text_q.push_back(CH_LBRACE);
        send_text();

        // Random texts
        while (random_sent < RANDOM_BYTES) begin
            build_random_text();
            src_calm = ($urandom_range(0, 4) == 0);
            random_sent += text_q.size();
            send_text();
        end
        s_tvalid <= 1'b0;

        // Drain outstanding results, then wait for strays
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
